### hw/rtl/nnd_pkg.sv
package nnd_pkg;

  localparam logic [7:0]  LETTER_LOW    = 8'h41;  // 'A'
  localparam logic [7:0]  LETTER_HIGH   = 8'h50;  // 'P'
  localparam logic [7:0]  SPACE_BYTE    = 8'd32;
  localparam logic [7:0]  SKIP_LIMIT    = 8'd20;
  localparam logic [15:0] MIN_LEN_RESET = 16'd48;
  localparam logic [4:0]  KEPT_MAX      = 5'd31;

  typedef struct packed {
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic        start_of_name;
    logic [15:0] packet_length;
  } nnd_in_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] name_byte;
    logic       name_done;
    logic [4:0] name_length;
    logic       bogus_header;
  } nnd_out_t;

  // per-packet decode flags carried between beats
  typedef struct packed {
    logic       stopped;
    logic [4:0] kept_count;
    logic       packet_bogus;
  } nnd_flags_t;

endpackage

### hw/rtl/nnd_step.sv
module nnd_step #(
  parameter int NAME_CHARS = 32,
  parameter int PW = 5
) (
  input  nnd_pkg::nnd_in_t    pair,
  input  logic [15:0]         min_packet_length,
  input  nnd_pkg::nnd_flags_t flags,
  input  logic [PW-1:0]       pair_count,
  output nnd_pkg::nnd_flags_t flags_next,
  output logic [PW-1:0]       pair_count_next,
  output nnd_pkg::nnd_out_t   result
);

  localparam int HALF = NAME_CHARS / 2;

  logic       bogus;
  logic       stop_base;
  logic [4:0] kept_base;
  logic [PW-1:0] pc_base;
  logic [PW-1:0] pc_inc;
  logic       c1_ok;
  logic       c2_ok;
  logic [7:0] c1_off;
  logic [7:0] c2_off;
  logic [7:0] dec;
  logic       stop_out;
  logic       valid_out;
  logic [7:0] byte_out;
  logic [4:0] kept_out;

  assign c1_ok  = (pair.first_char >= nnd_pkg::LETTER_LOW) &&
                  (pair.first_char <= nnd_pkg::LETTER_HIGH);
  assign c2_ok  = (pair.second_char >= nnd_pkg::LETTER_LOW) &&
                  (pair.second_char <= nnd_pkg::LETTER_HIGH);
  assign c1_off = pair.first_char - nnd_pkg::LETTER_LOW;
  assign c2_off = pair.second_char - nnd_pkg::LETTER_LOW;
  assign dec    = {c1_off[3:0], c2_off[3:0]};

  always_comb begin
    if (pair.start_of_name) begin
      bogus     = pair.packet_length <= min_packet_length;
      stop_base = pair.packet_length <= min_packet_length;
      kept_base = '0;
      pc_base   = '0;
    end else begin
      bogus     = flags.packet_bogus;
      stop_base = flags.stopped;
      kept_base = flags.kept_count;
      pc_base   = pair_count;
    end

    pc_inc    = pc_base + PW'(1);
    stop_out  = stop_base;
    valid_out = 1'b0;
    byte_out  = '0;
    kept_out  = kept_base;
    pair_count_next = pc_base;

    if (!stop_base) begin
      if (!c1_ok || !c2_ok) begin
        stop_out = 1'b1;
      end else begin
        byte_out = dec;
        if (dec == nnd_pkg::SPACE_BYTE) begin
          stop_out = 1'b1;
        end else if (dec > nnd_pkg::SKIP_LIMIT) begin
          valid_out = 1'b1;
          if (kept_base < nnd_pkg::KEPT_MAX) begin
            kept_out = kept_base + 5'd1;
          end
        end
      end
      pair_count_next = pc_inc;
      if (pc_inc >= PW'(HALF)) begin
        stop_out = 1'b1;
      end
    end
  end

  assign flags_next.stopped      = stop_out;
  assign flags_next.kept_count   = kept_out;
  assign flags_next.packet_bogus = bogus;

  assign result.byte_valid   = valid_out;
  assign result.name_byte    = byte_out;
  assign result.name_done    = stop_out;
  assign result.name_length  = kept_out;
  assign result.bogus_header = bogus;

endmodule

### hw/rtl/netbios_name_decoder_unit.sv
// NetBIOS first-level name decoder. One encoded character pair is taken per
// beat and one result beat comes back for it, one pair per cycle sustained
// while out_stall is low: a pair is held in the input register, is decoded by
// the step logic and lands in the output register. in_stall rises only when
// the input register is full and the output register is held by out_stall.
// min_packet_length (reset 48) is written over the cfg channel, which is
// always ready; write it only while no pair is in flight.
module netbios_name_decoder_unit #(
  parameter int NAME_CHARS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  nnd_pkg::nnd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output nnd_pkg::nnd_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  // pair counter must hold NAME_CHARS/2 itself
  localparam int HALF = NAME_CHARS / 2;
  localparam int PW   = $clog2(HALF + 1);

  // configuration
  logic [15:0] min_packet_length;

  // input register
  logic             s1_valid;
  nnd_pkg::nnd_in_t s1_data;

  // decode state
  nnd_pkg::nnd_flags_t flags;
  nnd_pkg::nnd_flags_t flags_next;
  logic [PW-1:0]       pair_count;
  logic [PW-1:0]       pair_count_next;
  nnd_pkg::nnd_out_t   result;

  logic out_load;
  logic in_take;

  // the output register moves when empty or being drained this cycle
  assign out_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !out_load;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_packet_length <= nnd_pkg::MIN_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_packet_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data <= in_data;
    end
  end

  nnd_step #(
    .NAME_CHARS(NAME_CHARS),
    .PW(PW)
  ) u_step (
    .pair(s1_data),
    .min_packet_length(min_packet_length),
    .flags(flags),
    .pair_count(pair_count),
    .flags_next(flags_next),
    .pair_count_next(pair_count_next),
    .result(result)
  );

  // state advances exactly when a pair commits to the output register;
  // no packet has started after reset, so stray pairs are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      flags.stopped      <= 1'b1;
      flags.kept_count   <= '0;
      flags.packet_bogus <= 1'b0;
      pair_count         <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (out_load) begin
        flags      <= flags_next;
        pair_count <= pair_count_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

  // kept bytes are never spaces or skipped control values
  a_kept_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_valid |->
      (out_data.name_byte > nnd_pkg::SKIP_LIMIT) &&
      (out_data.name_byte != nnd_pkg::SPACE_BYTE))
    else $error("kept byte out of range");

  // a bogus packet decodes nothing
  a_bogus_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bogus_header |->
      out_data.name_done && !out_data.byte_valid)
    else $error("bogus packet produced a byte");

  // once stopped, only a new start reopens decoding
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    flags.stopped && !(out_load && s1_data.start_of_name) |=> flags.stopped)
    else $error("decoder restarted without start of name");

  // pair counter never passes the name limit
  a_pair_limit: assert property (@(posedge clk) disable iff (rst)
    pair_count <= PW'(HALF))
    else $error("pair count past limit");

  // stall only with a pair waiting in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without backpressure");

endmodule
